// ===== rtl/lal_pkg.sv =====
// Package: constants, state type and fixed-point helpers for the Lorenz LFO.
package lal_pkg;

    localparam int STATE_W  = 32;
    localparam int OFFS_W   = 18;
    localparam int STEP_W   = 18;
    localparam int LEVEL_W  = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register index (word address)
    localparam logic REG_STEP_SIZE = 1'b0;

    localparam logic [STEP_W-1:0]         STEP_MAX   = 18'd167772;
    localparam logic signed [31:0]        Z_INIT     = 32'sd2464154;
    localparam logic signed [32:0]        COEF_B_Q16 = 33'sd1835008;
    localparam logic signed [31:0]        COEF_C_Q16 = 32'sd174763;
    localparam logic signed [33:0]        LEVEL_BIAS = 34'sd1310720;  // 0.5 * 40 in Q16
    localparam logic signed [33:0]        LEVEL_RND  = 34'sd20;
    localparam logic signed [33:0]        LEVEL_TOP  = 34'sd2621420;  // quotient reaches 65536
    // floor(m/5) = (m * 419431) >> 21, exact for m below 699050
    localparam logic signed [31:0]        RECIP_5    = 32'sd419431;
    localparam logic [LEVEL_W-1:0]        LEVEL_MAX  = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_P5,
        S_P6,
        S_P7,
        S_OUT
    } t_lal_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // add half, then arithmetic shift (floor)
    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s[63:16];
    endfunction

    function automatic logic signed [39:0] rnd24(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd8388608;
        return s[63:24];
    endfunction

endpackage

// ===== rtl/lal_in_if.sv =====
// Request channel carrying one sample tick with its reload offsets.
interface lal_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [17:0] offset_x;
    logic signed [17:0] offset_y;
    logic signed [17:0] offset_z;

    modport source (output valid, command, offset_x, offset_y, offset_z, input ready);
    modport sink   (input valid, command, offset_x, offset_y, offset_z, output ready);
endinterface

// ===== rtl/lal_out_if.sv =====
// Result channel carrying one LFO level.
interface lal_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] level;

    modport source (output valid, level, input ready);
    modport sink   (input valid, level, output ready);
endinterface

// ===== rtl/lorenz_attractor_lfo.sv =====
// Lorenz-system chaotic LFO: one forward-Euler step per sample tick, one level out.
//
// i_in (valid/ready): one request per sample tick. command = 0 advances the
// state one step; command = 1 first loads x, y from offset_x/offset_y and z
// from 37.6 + offset_z, then advances. o_out (valid/ready): one level per
// request, x/40 + 0.5 as unsigned Q0.16, saturated.
// APB port: register 0 (address 0) is step_size, Q0.24, used clamped to 0.01.
// Write it only while the block is idle.
//
// Timing: a request is taken only in the idle state. The step runs through
// seven passes of one shared 32x32 multiplier (three state products, three
// step scalings, one reciprocal multiply for the /40), then one output cycle:
// the level is registered there, and no new request is taken until the
// block is back in idle. If the receiver stalls, the level waits in the output
// register and the block holds in its output cycle with ready low.
// Reset (synchronous, active low) clears x and y, sets z to 37.6, step_size
// to 0 and drops the output valid.
module lorenz_attractor_lfo
    import lal_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    lal_in_if.sink              i_in,
    lal_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_lal_state r_state, n_state;

    logic [STEP_W-1:0]          r_step_size;
    logic signed [31:0]         r_x, r_y, r_z;
    logic signed [31:0]         r_d1, r_d2, r_d3;
    logic signed [47:0]         r_xy;
    logic signed [63:0]         r_prod;
    logic                       r_lvl_lo, r_lvl_hi;
    logic [LEVEL_W-1:0]         r_level;
    logic                       r_out_valid;

    logic                       in_acc;
    logic                       out_load;
    logic [STEP_W-1:0]          step_t;
    logic signed [32:0]         diff_yx;
    logic signed [36:0]         d1_full;
    logic signed [32:0]         bz_full;
    logic signed [33:0]         lvl_num;
    logic signed [33:0]         lvl_rnd;
    logic [18:0]                lvl_m;
    logic signed [31:0]         mul_a, mul_b;
    logic signed [63:0]         mul_p;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STEP_SIZE) ? APB_DW'(r_step_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP_SIZE) begin
            r_step_size <= pwdata[STEP_W-1:0];
        end
    end

    assign step_t = (r_step_size > STEP_MAX) ? STEP_MAX : r_step_size;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_P1;
            S_P1:    n_state = S_P2;
            S_P2:    n_state = S_P3;
            S_P3:    n_state = S_P4;
            S_P4:    n_state = S_P5;
            S_P5:    n_state = S_P6;
            S_P6:    n_state = S_P7;
            S_P7:    n_state = S_OUT;
            S_OUT:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_OUT:   out_load   = !r_out_valid || o_out.ready;
            default: begin
                i_in.ready = 1'b0;
                out_load   = 1'b0;
            end
        endcase
    end

    assign in_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.level = r_level;

    // ---------------- shared multiplier ----------------
    assign diff_yx = 33'(r_y) - 33'(r_x);
    assign d1_full = (37'(diff_yx) <<< 3) + (37'(diff_yx) <<< 1);
    assign bz_full = COEF_B_Q16 - 33'(r_z);

    assign lvl_num = 34'(r_x) + LEVEL_BIAS;
    assign lvl_rnd = lvl_num + LEVEL_RND;
    assign lvl_m   = lvl_rnd[21:3];   // (num + 20) / 8, valid when in range

    always_comb begin
        case (r_state)
            S_P1: begin
                mul_a = sat32(64'(bz_full));
                mul_b = r_x;
            end
            S_P2: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            S_P3: begin
                mul_a = r_z;
                mul_b = COEF_C_Q16;
            end
            S_P4: begin
                mul_a = r_d1;
                mul_b = 32'(step_t);
            end
            S_P5: begin
                mul_a = r_d2;
                mul_b = 32'(step_t);
            end
            S_P6: begin
                mul_a = r_d3;
                mul_b = 32'(step_t);
            end
            S_P7: begin
                mul_a = 32'(lvl_m);
                mul_b = RECIP_5;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // ---------------- datapath ----------------
    // each state consumes the product registered in the state before it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= Z_INIT;
        end else begin
            // level product stays put while the output cycle waits
            if (r_state != S_OUT)
                r_prod <= mul_p;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.command) begin
                        r_x <= 32'(i_in.offset_x);
                        r_y <= 32'(i_in.offset_y);
                        r_z <= Z_INIT + 32'(i_in.offset_z);
                    end
                end
                S_P1: r_d1 <= sat32(64'(d1_full));
                S_P2: r_d2 <= sat32(64'(rnd16(r_prod)) - 64'(r_y));
                S_P3: r_xy <= rnd16(r_prod);
                S_P4: r_d3 <= sat32(64'(r_xy) - 64'(rnd16(r_prod)));
                S_P5: r_x  <= sat32(64'(r_x) + 64'(rnd24(r_prod)));
                S_P6: r_y  <= sat32(64'(r_y) + 64'(rnd24(r_prod)));
                S_P7: begin
                    r_z      <= sat32(64'(r_z) + 64'(rnd24(r_prod)));
                    r_lvl_lo <= lvl_num < 34'sd0;
                    r_lvl_hi <= lvl_num >= LEVEL_TOP;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_lvl_lo)
                            r_level <= '0;
                        else if (r_lvl_hi)
                            r_level <= LEVEL_MAX;
                        else
                            r_level <= r_prod[36:21];
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_P1)
        else $error("accepted request did not start the step");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output valid rose outside the output cycle");

    a_low_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_lvl_lo) |=> o_out.level == '0)
        else $error("negative level not saturated to zero");

    a_step_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_t <= STEP_MAX)
        else $error("step size exceeds clamp");

endmodule
